/* rtl/core/ttpr_pkg.sv */
// ttpr_pkg: request and result types, operation codes, store sizes and the
// level-to-intensity table of the ternary tile pixel renderer
// no dependencies
package ttpr_pkg;

  typedef enum logic [1:0] {
    OP_CELL    = 2'd0,
    OP_PATTERN = 2'd1,
    OP_PALETTE = 2'd2,
    OP_RENDER  = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [12:0] cell_index;
    logic [4:0]  cell_palette;
    logic [9:0]  cell_tile;
    logic [12:0] pattern_row_index;
    logic [17:0] pattern_trits;
    logic [6:0]  palette_entry;
    logic [4:0]  level_red;
    logic [4:0]  level_green;
    logic [4:0]  level_blue;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
  } req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [9:0] out_x;
    logic [9:0] out_y;
  } rsp_t;

  localparam int unsigned StoreDepth   = 6561;
  localparam int unsigned StoreAw      = 13;
  localparam int unsigned PaletteDepth = 81;
  localparam int unsigned PaletteAw    = 7;
  localparam int unsigned CellWidth    = 15;
  localparam int unsigned RowWidth     = 18;
  localparam int unsigned ColorWidth   = 15;
  localparam int unsigned TileSize     = 9;
  localparam int unsigned MaxLevel     = 26;

  // x / 9 == (x * 911) >> 13 for every x below 1170
  localparam int unsigned DivNine      = 911;
  localparam int unsigned DivNineShift = 13;

  localparam logic [7:0] Intensity [27] = '{
    8'd0,   8'd10,  8'd20,  8'd29,  8'd39,  8'd49,  8'd59,  8'd69,  8'd78,
    8'd88,  8'd98,  8'd108, 8'd118, 8'd128, 8'd137, 8'd147, 8'd157, 8'd167,
    8'd177, 8'd186, 8'd196, 8'd206, 8'd216, 8'd226, 8'd235, 8'd245, 8'd255
  };

  function automatic logic [7:0] level_to_byte(logic [4:0] lvl);
    logic [7:0] res;
    if (lvl > 5'(MaxLevel)) begin
      res = Intensity[MaxLevel];
    end else begin
      res = Intensity[lvl];
    end
    return res;
  endfunction

endpackage

/* rtl/core/ttpr_ram.sv */
// ttpr_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module ttpr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ttpr_outbuf.sv */
// ttpr_outbuf: output register plus one skid entry for the result channel
// depends on ttpr_pkg
module ttpr_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  ttpr_pkg::rsp_t res_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          stall_i,
  output ttpr_pkg::rsp_t rsp_o
);
  import ttpr_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_full_q, skid_full_d;
  rsp_t out_q, out_d;
  rsp_t skid_q, skid_d;
  logic take;

  assign take = out_valid_q && !stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    skid_full_d = skid_full_q;
    out_d       = out_q;
    skid_d      = skid_q;
    if (skid_full_q) begin
      if (take) begin
        out_d       = skid_q;
        skid_full_d = 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_valid_d = res_valid_i;
      out_d       = res_i;
    end else if (res_valid_i) begin
      skid_d      = res_i;
      skid_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_full_q;
  assign valid_o = out_valid_q;
  assign rsp_o   = out_q;

endmodule

/* rtl/core/ternary_tile_pixel_renderer.sv */
// ternary_tile_pixel_renderer: top level, five-stage render pipeline over the
// cell, pattern and palette stores
// depends on ttpr_pkg, ttpr_ram, ttpr_outbuf
//
// usage: one request channel (valid_i, stall_o, req_i) carries store writes
// and render requests; one result channel (valid_o, stall_i, rsp_o) returns
// one pixel per render request, in request order. store writes return nothing.
// a request is taken at an edge with valid_i high and stall_o low.
// throughput: one request per cycle while stall_o is low. a render request
// passes stage registers 1 to 5, then the output register, to rsp_o. the
// cell store is read in stage 2, the pattern store in stage 3, the palette
// store in stage 4, and each store is written in the same stage that reads
// it, so writes and renders keep request order.
// reset empties the pipeline and the output buffer; store contents are not
// cleared and must be written before they are rendered.
// when the receiver stalls, the output register holds its pixel and one
// more result lands in the skid entry; stall_o then rises and the whole
// pipeline freezes until the receiver takes the held pixel.
module ternary_tile_pixel_renderer #(
  parameter int unsigned GRID_COLS = 81,
  parameter int unsigned GRID_ROWS = 81
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  ttpr_pkg::req_t req_i,
  output logic           valid_o,
  input  logic           stall_i,
  output ttpr_pkg::rsp_t rsp_o
);
  import ttpr_pkg::*;

  logic en;
  logic buf_full;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  req_t req1_q, req2_q, req3_q, req4_q, req5_q;

  // stage 2 payload
  logic [6:0] gx2_q, gy2_q;
  logic [3:0] xm2_q, ym2_q;
  // stage 3 payload
  logic [3:0] xm3_q, ym3_q;
  logic       grid3_q;
  // stage 4 payload
  logic [3:0] xm4_q;
  logic       grid4_q, pat_ok4_q;
  logic [4:0] pal4_q;
  // stage 5 payload
  logic       ok5_q;

  assign en      = !buf_full;
  assign stall_o = buf_full;

  // stage 1 -> 2: grid position by reciprocal multiply
  logic [19:0] xprod, yprod;
  logic [6:0]  gx, gy;
  logic [9:0]  gx9, gy9;
  logic [9:0]  xrem, yrem;

  always_comb begin
    xprod = 20'(req1_q.pixel_x) * 20'(DivNine);
    yprod = 20'(req1_q.pixel_y) * 20'(DivNine);
    gx    = xprod[19:DivNineShift];
    gy    = yprod[19:DivNineShift];
    gx9   = 10'({gx, 3'b000}) + 10'(gx);
    gy9   = 10'({gy, 3'b000}) + 10'(gy);
    xrem  = req1_q.pixel_x - gx9;
    yrem  = req1_q.pixel_y - gy9;
  end

  // stage 2 -> 3: cell index, cell store access
  logic        in_grid;
  logic [13:0] cidx;
  logic        cell_we;
  logic [StoreAw-1:0] cell_raddr;
  logic [CellWidth-1:0] cell_rdata;

  always_comb begin
    in_grid    = (gx2_q < 7'(GRID_COLS)) && (gy2_q < 7'(GRID_ROWS));
    cidx       = 14'(gy2_q) * 14'(GRID_COLS) + 14'(gx2_q);
    cell_raddr = in_grid ? cidx[StoreAw-1:0] : '0;
    cell_we    = en && v2_q && (req2_q.op == OP_CELL) &&
                 (req2_q.cell_index < 13'(StoreDepth));
  end

  ttpr_ram #(
    .WIDTH(CellWidth),
    .DEPTH(StoreDepth)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (cell_we),
    .waddr_i(req2_q.cell_index),
    .wdata_i({req2_q.cell_palette, req2_q.cell_tile}),
    .re_i   (en),
    .raddr_i(cell_raddr),
    .rdata_o(cell_rdata)
  );

  // stage 3 -> 4: pattern row address, pattern store access
  logic [13:0] paddr;
  logic        pat_ok;
  logic        pat_we;
  logic [StoreAw-1:0] pat_raddr;
  logic [RowWidth-1:0] pat_rdata;

  always_comb begin
    paddr     = 14'(cell_rdata[9:0]) * 14'(TileSize) + 14'(ym3_q);
    pat_ok    = paddr < 14'(StoreDepth);
    pat_raddr = pat_ok ? paddr[StoreAw-1:0] : '0;
    pat_we    = en && v3_q && (req3_q.op == OP_PATTERN) &&
                (req3_q.pattern_row_index < 13'(StoreDepth));
  end

  ttpr_ram #(
    .WIDTH(RowWidth),
    .DEPTH(StoreDepth)
  ) u_pattern_ram (
    .clk_i  (clk_i),
    .we_i   (pat_we),
    .waddr_i(req3_q.pattern_row_index),
    .wdata_i(req3_q.pattern_trits),
    .re_i   (en),
    .raddr_i(pat_raddr),
    .rdata_o(pat_rdata)
  );

  // stage 4 -> 5: trit select, palette store access
  logic [RowWidth-1:0] row;
  logic [RowWidth-1:0] row_sh;
  logic [3:0]  k;
  logic [1:0]  code, slot;
  logic [6:0]  cix;
  logic        cix_ok;
  logic        pal_we;
  logic [PaletteAw-1:0] pal_raddr;
  logic [ColorWidth-1:0] pal_rdata;

  always_comb begin
    row       = pat_ok4_q ? pat_rdata : '0;
    k         = 4'(TileSize - 1) - xm4_q;
    row_sh    = row >> {k, 1'b0};
    code      = row_sh[1:0];
    slot      = (code == 2'd3) ? 2'd1 : code;
    cix       = 7'({pal4_q, 1'b0}) + 7'(pal4_q) + 7'(slot);
    cix_ok    = cix < 7'(PaletteDepth);
    pal_raddr = cix_ok ? cix : '0;
    pal_we    = en && v4_q && (req4_q.op == OP_PALETTE) &&
                (req4_q.palette_entry < 7'(PaletteDepth));
  end

  ttpr_ram #(
    .WIDTH(ColorWidth),
    .DEPTH(PaletteDepth)
  ) u_palette_ram (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(req4_q.palette_entry),
    .wdata_i({req4_q.level_red, req4_q.level_green, req4_q.level_blue}),
    .re_i   (en),
    .raddr_i(pal_raddr),
    .rdata_o(pal_rdata)
  );

  // stage 5: intensity lookup
  logic res_valid;
  rsp_t res;

  always_comb begin
    res_valid     = v5_q && (req5_q.op == OP_RENDER);
    res.out_red   = ok5_q ? level_to_byte(pal_rdata[14:10]) : '0;
    res.out_green = ok5_q ? level_to_byte(pal_rdata[9:5]) : '0;
    res.out_blue  = ok5_q ? level_to_byte(pal_rdata[4:0]) : '0;
    res.out_x     = req5_q.pixel_x;
    res.out_y     = req5_q.pixel_y;
  end

  ttpr_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid && en),
    .res_i      (res),
    .full_o     (buf_full),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .rsp_o      (rsp_o)
  );

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      req1_q    <= req_i;
      req2_q    <= req1_q;
      gx2_q     <= gx;
      gy2_q     <= gy;
      xm2_q     <= xrem[3:0];
      ym2_q     <= yrem[3:0];
      req3_q    <= req2_q;
      xm3_q     <= xm2_q;
      ym3_q     <= ym2_q;
      grid3_q   <= in_grid;
      req4_q    <= req3_q;
      xm4_q     <= xm3_q;
      grid4_q   <= grid3_q;
      pat_ok4_q <= pat_ok;
      pal4_q    <= cell_rdata[14:10];
      req5_q    <= req4_q;
      ok5_q     <= grid4_q && cix_ok;
    end
  end

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_full |-> valid_o)
    else $error("skid entry full while output register empty");

  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v2_q) && $stable(v3_q) && $stable(v4_q) && $stable(v5_q))
    else $error("pipeline moved while frozen");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(res_valid && en))
    else $error("result appeared without a render request");

endmodule

/* tb/sv/ternary_tile_pixel_renderer_tb.sv */
// ternary_tile_pixel_renderer_tb: self-checking bench for the tile pixel renderer,
// directed table then random store writes and renders, checked against a local predictor
// depends on ttpr_pkg and ternary_tile_pixel_renderer
module ternary_tile_pixel_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttpr_pkg::*;

  localparam int unsigned GridCols = 81;
  localparam int unsigned GridRows = 81;
  localparam int unsigned TargetItems = 1000;
  localparam int unsigned QuietAfter = 850;

  localparam logic [7:0] Ramp [27] = '{
    8'd0,   8'd10,  8'd20,  8'd29,  8'd39,  8'd49,  8'd59,  8'd69,  8'd78,
    8'd88,  8'd98,  8'd108, 8'd118, 8'd128, 8'd137, 8'd147, 8'd157, 8'd167,
    8'd177, 8'd186, 8'd196, 8'd206, 8'd216, 8'd226, 8'd235, 8'd245, 8'd255
  };

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  req_t req_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  rsp_t rsp_o;

  bit [14:0] cell_mem [StoreDepth];
  bit [17:0] row_mem [StoreDepth];
  bit [14:0] color_mem [PaletteDepth];
  bit cell_set [StoreDepth];
  bit row_set [StoreDepth];
  bit color_set [PaletteDepth];

  rsp_t pixels_due [$];
  int unsigned drawn_cells [$];
  plan_row_t plan [$];
  int unsigned items = 0;
  int unsigned errors = 0;
  int unsigned gap_pct = 15;
  int unsigned hold_pct = 15;
  int unsigned hold_left = 0;
  bit quiet = 1'b0;

  ternary_tile_pixel_renderer #(
    .GRID_COLS(GridCols),
    .GRID_ROWS(GridRows)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .stall_o(stall_o),
    .req_i  (req_i),
    .valid_o(valid_o),
    .stall_i(stall_i),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("ternary_tile_pixel_renderer_tb NOT OK");
    $finish;
  end

  function automatic int unsigned pick_pct();
    int unsigned pct;
    case ($urandom_range(0, 2))
      0: pct = 0;
      1: pct = 15;
      default: pct = 50;
    endcase
    return pct;
  endfunction

  function automatic logic [7:0] level_byte(logic [4:0] lvl);
    return Ramp[(lvl > 5'd26) ? 5'd26 : lvl];
  endfunction

  function automatic rsp_t shade(logic [9:0] x, logic [9:0] y, output bit known);
    int unsigned gx, gy, cidx, paddr, code, slot, cix;
    logic [14:0] cell_word;
    logic [17:0] row;
    logic [14:0] col;
    rsp_t px;
    px = '0;
    px.out_x = x;
    px.out_y = y;
    known = 1'b1;
    gx = x / TileSize;
    gy = y / TileSize;
    if (gx < GridCols && gy < GridRows) begin
      cidx = gy * GridCols + gx;
      known = cell_set[cidx];
      cell_word = cell_mem[cidx];
      paddr = TileSize * cell_word[9:0] + y % TileSize;
      row = '0;
      if (paddr < StoreDepth) begin
        known = known & row_set[paddr];
        row = row_mem[paddr];
      end
      code = (row >> (2 * (8 - x % TileSize))) & 3;
      slot = (code == 3) ? 1 : code;
      cix = 3 * cell_word[14:10] + slot;
      if (cix < PaletteDepth) begin
        known = known & color_set[cix];
        col = color_mem[cix];
        px.out_red = level_byte(col[14:10]);
        px.out_green = level_byte(col[9:5]);
        px.out_blue = level_byte(col[4:0]);
      end
    end
    return px;
  endfunction

  function automatic bit store_write(req_t r);
    bit taken;
    taken = 1'b0;
    case (r.op)
      OP_CELL: if (r.cell_index < StoreDepth) begin
        cell_mem[r.cell_index] = {r.cell_palette, r.cell_tile};
        cell_set[r.cell_index] = 1'b1;
        taken = 1'b1;
      end
      OP_PATTERN: if (r.pattern_row_index < StoreDepth) begin
        row_mem[r.pattern_row_index] = r.pattern_trits;
        row_set[r.pattern_row_index] = 1'b1;
        taken = 1'b1;
      end
      OP_PALETTE: if (r.palette_entry < PaletteDepth) begin
        color_mem[r.palette_entry] = {r.level_red, r.level_green, r.level_blue};
        color_set[r.palette_entry] = 1'b1;
        taken = 1'b1;
      end
      default: ;
    endcase
    return taken;
  endfunction

  // unused fields carry random bits
  function automatic req_t scramble(op_e op);
    logic [127:0] bits;
    req_t r;
    bits = {$urandom, $urandom, $urandom, $urandom};
    r = bits[$bits(req_t)-1:0];
    r.op = op;
    return r;
  endfunction

  function automatic req_t cell_req(int unsigned idx, int unsigned pal, int unsigned tile);
    req_t r;
    r = scramble(OP_CELL);
    r.cell_index = 13'(idx);
    r.cell_palette = 5'(pal);
    r.cell_tile = 10'(tile);
    return r;
  endfunction

  function automatic req_t row_req(int unsigned idx, int unsigned trits);
    req_t r;
    r = scramble(OP_PATTERN);
    r.pattern_row_index = 13'(idx);
    r.pattern_trits = 18'(trits);
    return r;
  endfunction

  function automatic req_t color_req(int unsigned idx, int unsigned red, int unsigned green,
                                     int unsigned blue);
    req_t r;
    r = scramble(OP_PALETTE);
    r.palette_entry = 7'(idx);
    r.level_red = 5'(red);
    r.level_green = 5'(green);
    r.level_blue = 5'(blue);
    return r;
  endfunction

  function automatic req_t pix_req(int unsigned x, int unsigned y);
    req_t r;
    r = scramble(OP_RENDER);
    r.pixel_x = 10'(x);
    r.pixel_y = 10'(y);
    return r;
  endfunction

  function automatic rsp_t pixel(int unsigned red, int unsigned green, int unsigned blue,
                                 int unsigned x, int unsigned y);
    rsp_t px;
    px.out_red = 8'(red);
    px.out_green = 8'(green);
    px.out_blue = 8'(blue);
    px.out_x = 10'(x);
    px.out_y = 10'(y);
    return px;
  endfunction

  task automatic send(req_t r, bit typed, rsp_t want);
    int unsigned n;
    bit ok;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 9);
      valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    if (r.op == OP_RENDER) begin
      if (typed) begin
        pixels_due.push_back(want);
      end else begin
        pixels_due.push_back(shade(r.pixel_x, r.pixel_y, ok));
      end
      items++;
    end else if (store_write(r)) begin
      items++;
    end
    if ($urandom_range(0, 63) == 0) begin
      gap_pct = pick_pct();
    end
  endtask

  // render only pixels whose cell, row and color have all been written, where each lies in the grid or its store
  task automatic try_render(int unsigned x, int unsigned y);
    bit ok;
    void'(shade(10'(x), 10'(y), ok));
    if (ok) begin
      send(pix_req(x, y), 1'b0, '0);
    end
  endtask

  task automatic paint_cell();
    int unsigned gx, gy, cidx, pal, tile, n;
    gx = $urandom_range(0, GridCols - 1);
    gy = $urandom_range(0, GridRows - 1);
    cidx = gy * GridCols + gx;
    pal = ($urandom_range(0, 9) == 0) ? $urandom_range(27, 31) : $urandom_range(0, 26);
    if ($urandom_range(0, 9) == 0) begin
      tile = $urandom_range(729, 1023);
    end else if ($urandom_range(0, 1) == 0) begin
      tile = $urandom_range(0, 15);
    end else begin
      tile = $urandom_range(0, 728);
    end
    send(cell_req(cidx, pal, tile), 1'b0, '0);
    if (tile < 729) begin
      for (int unsigned k = 0; k < TileSize; k++) begin
        if (!row_set[TileSize * tile + k] || $urandom_range(0, 3) == 0) begin
          send(row_req(TileSize * tile + k, $urandom_range(0, 262143)), 1'b0, '0);
        end
      end
    end
    if (pal < 27) begin
      for (int unsigned s = 0; s < 3; s++) begin
        if (!color_set[3 * pal + s] || $urandom_range(0, 3) == 0) begin
          send(color_req(3 * pal + s, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 31)), 1'b0, '0);
        end
      end
    end
    drawn_cells.push_back(cidx);
    n = $urandom_range(1, 5);
    repeat (n) begin
      try_render(gx * TileSize + $urandom_range(0, 8), gy * TileSize + $urandom_range(0, 8));
    end
  endtask

  task automatic compare(string what, logic [9:0] want, logic [9:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : pixel_sink
    rsp_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (pixels_due.size() == 0) begin
        errors++;
        $display("%0t pixel expected none actual %p", $time, rsp_o);
      end else begin
        want = pixels_due.pop_front();
        compare("red", 10'(want.out_red), 10'(rsp_o.out_red));
        compare("green", 10'(want.out_green), 10'(rsp_o.out_green));
        compare("blue", 10'(want.out_blue), 10'(rsp_o.out_blue));
        compare("x", want.out_x, rsp_o.out_x);
        compare("y", want.out_y, rsp_o.out_y);
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < hold_pct) begin
      hold_left = $urandom_range(0, 8);
      stall_i <= 1'b1;
    end else begin
      stall_i <= 1'b0;
    end
    if ($urandom_range(0, 127) == 0) begin
      hold_pct = pick_pct();
    end
  end

  initial begin : stimulus
    int unsigned pick, cidx;
    // pixels outside the grid come back black
    plan.push_back('{pix_req(800, 5), 1'b1, pixel(0, 0, 0, 800, 5)});
    plan.push_back('{pix_req(0, 1023), 1'b1, pixel(0, 0, 0, 0, 1023)});
    plan.push_back('{pix_req(1023, 1023), 1'b1, pixel(0, 0, 0, 1023, 1023)});
    plan.push_back('{color_req(0, 31, 0, 13), 1'b0, '0});
    plan.push_back('{color_req(1, 0, 26, 0), 1'b0, '0});
    plan.push_back('{color_req(2, 26, 26, 26), 1'b0, '0});
    plan.push_back('{color_req(78, 1, 2, 3), 1'b0, '0});
    plan.push_back('{color_req(127, 5, 5, 5), 1'b0, '0});
    // row 0: plus, minus, zero, code three from the left
    plan.push_back('{row_req(0, 18'h21C00), 1'b0, '0});
    plan.push_back('{row_req(6560, 18'h3FFFF), 1'b0, '0});
    plan.push_back('{row_req(8191, 18'h0), 1'b0, '0});
    plan.push_back('{cell_req(0, 0, 0), 1'b0, '0});
    plan.push_back('{cell_req(8191, 0, 0), 1'b0, '0});
    plan.push_back('{pix_req(0, 0), 1'b1, pixel(255, 255, 255, 0, 0)});
    plan.push_back('{pix_req(1, 0), 1'b1, pixel(255, 0, 128, 1, 0)});
    plan.push_back('{pix_req(2, 0), 1'b1, pixel(0, 255, 0, 2, 0)});
    plan.push_back('{pix_req(3, 0), 1'b1, pixel(0, 255, 0, 3, 0)});
    // tile select past the pattern store reads as minus
    plan.push_back('{cell_req(6560, 26, 1023), 1'b0, '0});
    plan.push_back('{pix_req(728, 728), 1'b0, '0});
    plan.push_back('{cell_req(6559, 0, 728), 1'b0, '0});
    plan.push_back('{pix_req(719, 728), 1'b0, '0});
    plan.push_back('{cell_req(1, 31, 0), 1'b0, '0});
    plan.push_back('{pix_req(9, 0), 1'b1, pixel(0, 0, 0, 9, 0)});
    plan.push_back('{color_req(80, 13, 13, 13), 1'b0, '0});
    plan.push_back('{cell_req(2, 26, 0), 1'b0, '0});
    plan.push_back('{pix_req(18, 0), 1'b1, pixel(128, 128, 128, 18, 0)});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send(plan[i].req, plan[i].typed, plan[i].want);
    end
    drawn_cells.push_back(0);
    drawn_cells.push_back(2);

    while (items < TargetItems) begin
      quiet = (items >= QuietAfter);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        paint_cell();
      end else if (pick < 75) begin
        cidx = drawn_cells[$urandom_range(0, drawn_cells.size() - 1)];
        try_render((cidx % GridCols) * TileSize + $urandom_range(0, 8),
                   (cidx / GridCols) * TileSize + $urandom_range(0, 8));
      end else if (pick < 88) begin
        try_render($urandom_range(0, 1023), $urandom_range(0, 1023));
      end else begin
        send(scramble(op_e'($urandom_range(0, 2))), 1'b0, '0);
      end
    end
    quiet = 1'b1;
    valid_i <= 1'b0;

    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pixels_due.size() == 0) begin
      $display("ternary_tile_pixel_renderer_tb OK");
    end else begin
      $display("ternary_tile_pixel_renderer_tb NOT OK");
    end
    $finish;
  end

endmodule

/* ternary_tile_pixel_renderer.f */
rtl/core/ttpr_pkg.sv
rtl/core/ttpr_ram.sv
rtl/core/ttpr_outbuf.sv
rtl/core/ternary_tile_pixel_renderer.sv
tb/sv/ternary_tile_pixel_renderer_tb.sv
